### sv/gdd_pkg.sv
// gdd_pkg: types, constants and calendar helpers for the gregorian date difference block
// no dependencies; imported by gregorian_date_difference_top
`default_nettype none

package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned DNUM_W  = 22;   // day number of 31 dec 9999 is below 2**22
  localparam int unsigned CENT_W  = 8;    // year / 100 for a 14 bit year

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
  localparam logic [12:0]        RECIP_100   = 13'd5243;  // 2**19 / 100, exact below 43699
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [8:0]         DAYS_YEAR   = 9'd365;
  localparam logic [6:0]         CENTURY     = 7'd100;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic               include_end_day;
  } gdd_req_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_invalid;
  } gdd_res_t;

  // one date after the range checks
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [CENT_W-1:0]  prev_cent;   // (year - 1) / 100
    logic               leap;
    logic               ok;
  } gdd_date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic gdd_date_t date_check(input logic [DAY_W-1:0]   d,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [YEAR_W-1:0]  y);
    gdd_date_t          o;
    logic [26:0]        prod;
    logic [CENT_W-1:0]  cent;
    logic [YEAR_W-1:0]  rem;
    logic               rem_zero;
    prod     = 27'(y) * 27'(RECIP_100);
    cent     = prod[RECIP_SHIFT +: CENT_W];
    rem      = y - YEAR_W'(14'(cent) * 14'(CENTURY));
    rem_zero = (rem == '0);
    o.day       = d;
    o.month     = m;
    o.year      = y;
    o.leap      = ((y[1:0] == 2'd0) && !rem_zero) || (rem_zero && (cent[1:0] == 2'd0));
    // year - 1 crosses a century boundary only when year is a multiple of 100
    o.prev_cent = rem_zero ? cent - 8'd1 : cent;
    o.ok        = (y != '0) && (y <= YEAR_MAX) && (m != '0) && (m <= MONTHS) &&
                  (d != '0) && (d <= month_len(m, o.leap));
    return o;
  endfunction

  // proleptic day number, 1 for 1 january of year 1
  function automatic logic [DNUM_W-1:0] day_number(input gdd_date_t dt);
    logic [YEAR_W-1:0] p;
    logic [DNUM_W-1:0] n;
    p = dt.year - 14'd1;
    n = DNUM_W'(22'(p) * 22'(DAYS_YEAR)) + DNUM_W'(p >> 2)
      - DNUM_W'(dt.prev_cent) + DNUM_W'(dt.prev_cent >> 2)
      + DNUM_W'(days_before(dt.month))
      + DNUM_W'(dt.leap && (dt.month > FEBRUARY))
      + DNUM_W'(dt.day);
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/gregorian_date_difference_top.sv
// gregorian_date_difference_top: signed day count between two gregorian dates
// depends on gdd_pkg for the item types and calendar functions
//
//   port      dir  width  role
//   start_i   in   1      item offered on req_i
//   busy_o    out  1      always low, an item is taken every cycle
//   req_i     in   47     gdd_req_t, two dates and the end day flag
//   done_o    out  1      strobe, res_o holds a result for this cycle only
//   res_o     out  24     gdd_res_t, day difference and invalid flag
//
// four register stages: input, date check, day numbers, result
// done_o rises when the result register is loaded, after the input, date check and day
// number registers; one result per cycle
// reset clears the stage valid bits only; no clearing pass is needed
// the receiver cannot stall, so nothing is ever held back
`default_nettype none

module gregorian_date_difference_top import gdd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire gdd_req_t req_i,
  output logic          done_o,
  output gdd_res_t      res_o
);

  logic              in_vld_q;
  gdd_req_t          in_q;
  logic              s1_vld_q;
  gdd_date_t         s1_first_q, s1_second_q;
  logic              s1_inc_q;
  gdd_date_t         s1_first_d, s1_second_d;
  logic              s2_vld_q;
  logic [DNUM_W-1:0] s2_n1_q, s2_n2_q;
  logic              s2_ok_q, s2_inc_q;
  logic              out_vld_q;
  gdd_res_t          res_q, res_d;
  logic              earlier;
  logic [DNUM_W-1:0] mag;
  logic [DIFF_W-1:0] mag_inc;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      s1_vld_q  <= in_vld_q;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  assign s1_first_d  = date_check(in_q.first_day, in_q.first_month, in_q.first_year);
  assign s1_second_d = date_check(in_q.second_day, in_q.second_month, in_q.second_year);

  // stage 3: order, magnitude and sign
  always_comb begin
    earlier = s2_n1_q < s2_n2_q;
    mag     = earlier ? s2_n2_q - s2_n1_q : s2_n1_q - s2_n2_q;
    mag_inc = DIFF_W'(mag) + DIFF_W'(s2_inc_q);
    res_d.date_invalid = !s2_ok_q;
    if (!s2_ok_q) begin
      res_d.day_difference = '0;
    end else if (earlier) begin
      res_d.day_difference = mag_inc;
    end else begin
      res_d.day_difference = -mag_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= req_i;
    end
    s1_first_q  <= s1_first_d;
    s1_second_q <= s1_second_d;
    s1_inc_q    <= in_q.include_end_day;
    s2_n1_q     <= day_number(s1_first_q);
    s2_n2_q     <= day_number(s1_second_q);
    s2_ok_q     <= s1_first_q.ok && s1_second_q.ok;
    s2_inc_q    <= s1_inc_q;
    res_q       <= res_d;
  end

  assign done_o = out_vld_q;
  assign res_o  = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("accepted item did not complete after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s2_vld_q))
    else $error("result strobe without an item in the day number stage");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.date_invalid |-> res_o.day_difference == '0)
    else $error("invalid date gave a nonzero difference");

  a_inc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.date_invalid && $past(s2_inc_q) |-> res_o.day_difference != '0)
    else $error("end day included but difference is zero");

endmodule

`default_nettype wire
